// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the cache RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on clk_i, disabled in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication form
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/dmwtc_pkg.sv
// Package: constants, payload types and state encodings of the cache
`default_nettype none
package dmwtc_pkg;
  localparam int Procs     = 4;
  localparam int Lines     = 16;
  localparam int LineBytes = 16;
  localparam int MemBytes  = 4096;
  localparam int PageBytes = 256;
  localparam int Frames    = MemBytes / PageBytes;

  localparam int ProcW  = $clog2(Procs);
  localparam int IdxW   = $clog2(Lines);
  localparam int OffW   = $clog2(LineBytes);
  localparam int PageW  = $clog2(PageBytes);
  localparam int MemAw  = $clog2(MemBytes);
  localparam int TagW   = MemAw - OffW;
  localparam int SlotW  = ProcW + IdxW;
  localparam int Slots  = Procs * Lines;
  localparam int DataAw = SlotW + OffW;

  typedef enum logic [2:0] {
    FUNC_READ   = 3'd0,
    FUNC_WRITE  = 3'd1,
    FUNC_INVAL  = 3'd2,
    FUNC_FLUSHP = 3'd3,
    FUNC_FLUSHA = 3'd4,
    FUNC_BWRITE = 3'd5
  } func_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  proc;
    logic [12:0] address;
    logic [7:0]  write_data;
    logic [4:0]  frame;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  read_data;
    logic        hit;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } out_item_t;

  // Operation classes decided by the front part
  typedef enum logic [2:0] {
    OP_NONE, OP_READ, OP_WRITE, OP_INVAL, OP_FLUSHP, OP_FLUSHA, OP_BWRITE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              status;
    logic              pok;
    logic [ProcW-1:0]  proc;
    logic [MemAw-1:0]  addr;
    logic [7:0]        wdata;
    logic [4:0]        frame;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MEMCLR, ST_LOOK, ST_FILL, ST_ACCESS, ST_WALK, ST_RESULT
  } state_e;
endpackage
`default_nettype wire

// File: hw/rtl/direct_mapped_write_through_cache.sv
// Top level: direct-mapped write-through cache, front queue and back engine
// The back engine works on one item at a time.
// The line fill (one backing byte per cycle) and the slot walk set the long cases.
// After reset the backing memory (MemBytes, 4096 bytes) is cleared; items
// are queued (two deep) but not executed until that pass completes.
`default_nettype none
module direct_mapped_write_through_cache (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  dmwtc_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output dmwtc_pkg::out_item_t  out_data_o
);
  logic cmd_valid, cmd_pop;
  dmwtc_pkg::cmd_t cmd;

  dmwtc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  dmwtc_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
`default_nettype wire

// File: hw/rtl/dmwtc_front.sv
// Front part: accepts items, checks them, queues classified commands
`default_nettype none
module dmwtc_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  dmwtc_pkg::in_item_t  in_data_i,
  output logic                 cmd_valid_o,
  input  wire                  cmd_pop_i,
  output dmwtc_pkg::cmd_t      cmd_o
);
  `include "assert_macros.svh"
  dmwtc_pkg::cmd_t cq_q [2];
  logic       wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  dmwtc_pkg::cmd_t c;
  logic push, pok, aok;

  // Classify the incoming item
  always_comb begin
    pok = ({1'b0, in_data_i.proc} < 4'(dmwtc_pkg::Procs));
    aok = ({1'b0, in_data_i.address} < 14'(dmwtc_pkg::MemBytes));
    c = '0;
    c.pok = pok;
    c.proc = in_data_i.proc[dmwtc_pkg::ProcW-1:0];
    c.addr = in_data_i.address[dmwtc_pkg::MemAw-1:0];
    c.wdata = in_data_i.write_data;
    c.frame = in_data_i.frame;
    c.op = dmwtc_pkg::OP_NONE;
    case (in_data_i.func)
      dmwtc_pkg::FUNC_READ, dmwtc_pkg::FUNC_WRITE: begin
        if (pok && aok) begin
          c.op = (in_data_i.func == dmwtc_pkg::FUNC_READ) ? dmwtc_pkg::OP_READ
                                                           : dmwtc_pkg::OP_WRITE;
        end else begin
          c.status = 1'b1;
        end
      end
      dmwtc_pkg::FUNC_INVAL: begin
        if (in_data_i.frame != 5'd0 && {1'b0, in_data_i.frame} < 6'(dmwtc_pkg::Frames)) begin
          c.op = dmwtc_pkg::OP_INVAL;
        end
      end
      dmwtc_pkg::FUNC_FLUSHP: begin
        if (pok) c.op = dmwtc_pkg::OP_FLUSHP;
        else c.status = 1'b1;
      end
      dmwtc_pkg::FUNC_FLUSHA: c.op = dmwtc_pkg::OP_FLUSHA;
      dmwtc_pkg::FUNC_BWRITE: begin
        if (aok) c.op = dmwtc_pkg::OP_BWRITE;
        else c.status = 1'b1;
      end
      default: c.op = dmwtc_pkg::OP_NONE;
    endcase
  end

  // Two-entry command queue
  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = cq_q[rp_q];

  always_comb begin
    wp_d = wp_q ^ push;
    rp_d = rp_q ^ cmd_pop_i;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) cq_q[wp_q] <= c;
  end

  `ASSERT_IMPL(a_no_pop_empty, cmd_pop_i, cnt_q != 2'd0, "pop from empty queue")
  `ASSERT_CLK(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
  `ASSERT_IMPL(a_ptr_match, cnt_q == 2'd0 || cnt_q == 2'd2, wp_q == rp_q, "queue pointers")
endmodule
`default_nettype wire

// File: hw/rtl/dmwtc_back.sv
// Back part: tags, line data, backing memory, counters and sequencer
`default_nettype none
module dmwtc_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cmd_valid_i,
  output logic                  cmd_pop_o,
  input  dmwtc_pkg::cmd_t       cmd_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output dmwtc_pkg::out_item_t  out_data_o
);
  `include "assert_macros.svh"
  localparam int IW = dmwtc_pkg::IdxW;
  localparam int OW = dmwtc_pkg::OffW;
  localparam int MW = dmwtc_pkg::MemAw;
  localparam int TW = dmwtc_pkg::TagW;
  localparam int SW = dmwtc_pkg::SlotW;
  localparam int DW = dmwtc_pkg::DataAw;

  // Memories
  logic [7:0]    mem   [dmwtc_pkg::MemBytes];
  logic [7:0]    lbyte [1 << DW];
  logic [TW-1:0] ltag  [dmwtc_pkg::Slots];
  logic [dmwtc_pkg::Slots-1:0] lvalid_q;
  logic [31:0] hits_q [dmwtc_pkg::Procs];
  logic [31:0] miss_q [dmwtc_pkg::Procs];

  dmwtc_pkg::state_e st_q, st_d;
  dmwtc_pkg::cmd_t   cur_q;
  logic [MW:0]   cnt_q, cnt_d;
  logic [TW-1:0] tag_rd_q;
  logic [7:0]    mem_rd_q, lb_rd_q;
  logic          hit_q, hit_d;
  logic          ov_q;
  dmwtc_pkg::out_item_t od_q;

  logic [TW-1:0] ctag;
  logic [SW-1:0] cslot, wslot, tag_raddr;
  logic [OW-1:0] coff;
  logic [MW-1:0] mrd_addr;
  logic          mem_we, lb_we, fin;
  logic [DW-1:0] lb_waddr, lb_raddr;
  logic [7:0]    lb_wdata;
  logic          cnt_hit, cnt_miss, set_valid, clr_p, clr_all, walk_clr;
  logic [TW-1:0] wtag;

  assign ctag  = cur_q.addr[MW-1:OW];
  assign coff  = cur_q.addr[OW-1:0];
  assign cslot = {cur_q.proc, ctag[IW-1:0]};
  // walk compares the slot whose tag was read on the previous cycle
  assign wslot = SW'(cnt_q - 1'b1);
  assign wtag  = tag_rd_q;

  // Sequencer
  always_comb begin
    st_d = st_q;
    cnt_d = cnt_q;
    hit_d = hit_q;
    cmd_pop_o = 1'b0;
    mem_we = 1'b0;
    lb_we = 1'b0;
    lb_waddr = {cslot, coff};
    lb_wdata = cur_q.wdata;
    lb_raddr = {cslot, coff};
    mrd_addr = {ctag, cnt_q[OW-1:0]};
    tag_raddr = {cmd_i.proc, cmd_i.addr[OW+IW-1:OW]};
    cnt_hit = 1'b0;
    cnt_miss = 1'b0;
    set_valid = 1'b0;
    clr_p = 1'b0;
    clr_all = 1'b0;
    walk_clr = 1'b0;
    fin = 1'b0;
    case (st_q)
      dmwtc_pkg::ST_MEMCLR: begin
        mem_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[MW-1:0] == MW'(dmwtc_pkg::MemBytes - 1)) begin
          st_d = dmwtc_pkg::ST_IDLE;
          cnt_d = '0;
        end
      end
      dmwtc_pkg::ST_IDLE: begin
        // a held result that leaves at this edge frees the output register
        if (cmd_valid_i && (!ov_q || !out_stall_i)) begin
          cmd_pop_o = 1'b1;
          cnt_d = '0;
          st_d = dmwtc_pkg::ST_RESULT;
          case (cmd_i.op)
            dmwtc_pkg::OP_READ, dmwtc_pkg::OP_WRITE: st_d = dmwtc_pkg::ST_LOOK;
            dmwtc_pkg::OP_INVAL: st_d = dmwtc_pkg::ST_WALK;
            default: st_d = dmwtc_pkg::ST_RESULT;
          endcase
        end
      end
      dmwtc_pkg::ST_LOOK: begin
        hit_d = lvalid_q[cslot] && (tag_rd_q == ctag);
        if (lvalid_q[cslot] && (tag_rd_q == ctag)) begin
          cnt_hit = 1'b1;
          st_d = dmwtc_pkg::ST_ACCESS;
        end else begin
          cnt_miss = 1'b1;
          cnt_d = '0;
          st_d = dmwtc_pkg::ST_FILL;
        end
      end
      dmwtc_pkg::ST_FILL: begin
        // cnt counts requested bytes; the data arrives in the next cycle
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          lb_we = 1'b1;
          lb_waddr = {cslot, OW'(cnt_q - 1'b1)};
          lb_wdata = mem_rd_q;
        end
        if (cnt_q == (MW+1)'(dmwtc_pkg::LineBytes)) begin
          set_valid = 1'b1;
          st_d = dmwtc_pkg::ST_ACCESS;
        end
      end
      dmwtc_pkg::ST_ACCESS: begin
        if (cur_q.op == dmwtc_pkg::OP_WRITE) begin
          lb_we = 1'b1;
          mem_we = 1'b1;
        end
        st_d = dmwtc_pkg::ST_RESULT;
      end
      dmwtc_pkg::ST_WALK: begin
        // one tag read per cycle, each compared in the following cycle
        tag_raddr = cnt_q[SW-1:0];
        walk_clr = (cnt_q != '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (MW+1)'(dmwtc_pkg::Slots)) st_d = dmwtc_pkg::ST_RESULT;
      end
      dmwtc_pkg::ST_RESULT: begin
        fin = 1'b1;
        clr_p = (cur_q.op == dmwtc_pkg::OP_FLUSHP);
        clr_all = (cur_q.op == dmwtc_pkg::OP_FLUSHA);
        if (cur_q.op == dmwtc_pkg::OP_BWRITE) mem_we = 1'b1;
        st_d = dmwtc_pkg::ST_IDLE;
      end
      default: st_d = dmwtc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dmwtc_pkg::ST_MEMCLR;
      cnt_q <= '0;
      hit_q <= 1'b0;
      ov_q <= 1'b0;
      lvalid_q <= '0;
      for (int p = 0; p < dmwtc_pkg::Procs; p++) begin
        hits_q[p] <= '0;
        miss_q[p] <= '0;
      end
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      hit_q <= hit_d;
      if (fin) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      if (cnt_hit) hits_q[cur_q.proc] <= hits_q[cur_q.proc] + 32'd1;
      if (cnt_miss) miss_q[cur_q.proc] <= miss_q[cur_q.proc] + 32'd1;
      if (set_valid) lvalid_q[cslot] <= 1'b1;
      // a line lies inside the page when its tag's upper bits equal the frame
      if (walk_clr && lvalid_q[wslot]
          && (wtag >> (dmwtc_pkg::PageW - OW)) == TW'(cur_q.frame)) begin
        lvalid_q[wslot] <= 1'b0;
      end
      if (clr_p) begin
        for (int i = 0; i < dmwtc_pkg::Lines; i++) begin
          lvalid_q[{cur_q.proc, IW'(i)}] <= 1'b0;
        end
      end
      if (clr_all) begin
        lvalid_q <= '0;
        for (int p = 0; p < dmwtc_pkg::Procs; p++) begin
          hits_q[p] <= '0;
          miss_q[p] <= '0;
        end
      end
    end
  end

  // Memory and payload registers
  always_ff @(posedge clk_i) begin
    if (st_q == dmwtc_pkg::ST_IDLE && cmd_pop_o) cur_q <= cmd_i;
    tag_rd_q <= ltag[tag_raddr];
    mem_rd_q <= mem[mrd_addr];
    lb_rd_q <= lbyte[lb_raddr];
    if (set_valid) ltag[cslot] <= ctag;
    if (lb_we) lbyte[lb_waddr] <= lb_wdata;
    if (mem_we) begin
      if (st_q == dmwtc_pkg::ST_MEMCLR) mem[cnt_q[MW-1:0]] <= 8'd0;
      else mem[cur_q.addr] <= cur_q.wdata;
    end
    if (fin) begin
      od_q.status <= cur_q.status;
      od_q.read_data <= (cur_q.op == dmwtc_pkg::OP_READ) ? lb_rd_q : 8'd0;
      od_q.hit <= (cur_q.op == dmwtc_pkg::OP_READ || cur_q.op == dmwtc_pkg::OP_WRITE)
                  ? hit_q : 1'b0;
      od_q.hit_count <= cur_q.pok ? (clr_all ? 32'd0 : hits_q[cur_q.proc]) : 32'd0;
      od_q.miss_count <= cur_q.pok ? (clr_all ? 32'd0 : miss_q[cur_q.proc]) : 32'd0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  `ASSERT_IMPL(a_pop_idle, cmd_pop_o, st_q == dmwtc_pkg::ST_IDLE, "pop outside idle")
  `ASSERT_IMPL(a_one_result, fin, !ov_q || !out_stall_i, "result overwritten")
  `ASSERT_IMPL(a_fill_hit, st_q == dmwtc_pkg::ST_FILL, !hit_q, "fill after hit")
endmodule
`default_nettype wire
